### hdl/qgm_pkg.sv
// Shared types, gate codes and elaboration-time constants for the gate matrix generator.
package qgm_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int VAL_FRAC     = 16;
  localparam int VAL_W        = VAL_FRAC + 2;
  localparam int WORK_FRAC    = VAL_FRAC + 4;
  localparam int CORDIC_STEPS = VAL_FRAC + 4;
  localparam int XY_W         = WORK_FRAC + 4;
  localparam int Z_W          = 44;
  localparam int QT_W         = 41;
  localparam int NUM_LANES    = 5;
  localparam int NUM_OUT      = 8;
  // Angle scaling stage, starting vector, rotations and the rounding stage.
  localparam int LANE_LAT     = CORDIC_STEPS + 3;

  typedef logic [ANGLE_BITS-1:0]       phase_t;
  typedef logic signed [VAL_W-1:0]     val_t;
  typedef logic signed [XY_W-1:0]      xy_t;
  typedef logic signed [Z_W-1:0]       zval_t;
  typedef zval_t                       arc_tab_t [CORDIC_STEPS];
  typedef phase_t                      phase_arr_t [NUM_LANES];

  typedef struct packed {
    val_t co;
    val_t si;
  } cs_t;

  typedef cs_t cs_arr_t [NUM_LANES];
  typedef val_t mat_t [NUM_OUT];

  typedef enum logic [3:0] {
    CMD_U      = 4'd0,
    CMD_U2     = 4'd1,
    CMD_U1     = 4'd2,
    CMD_ID     = 4'd3,
    CMD_X      = 4'd4,
    CMD_Y      = 4'd5,
    CMD_Z      = 4'd6,
    CMD_H      = 4'd7,
    CMD_S      = 4'd8,
    CMD_T      = 4'd9,
    CMD_RX     = 4'd10,
    CMD_RY     = 4'd11,
    CMD_RZ     = 4'd12,
    CMD_EXPI_I = 4'd13,
    CMD_EXPI_Z = 4'd14,
    CMD_SH     = 4'd15
  } cmd_t;

  // Unsigned 64-bit quotient by shift and subtract.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of two to the minus i, Q60, from the odd power series.
  function automatic longint arc_pow2_q60(int i);
    longint sum;
    longint t;
    int     e;
    bit     stop;
    sum  = 0;
    stop = 1'b0;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e >= 60) stop = 1'b1;
      if (!stop) begin
        t   = longint'(udiv64(64'd1 << (60 - e), 64'(2 * k + 1)));
        sum = (k % 2 == 1) ? sum - t : sum + t;
      end
    end
    return sum;
  endfunction

  // Quarter pi in Q60 from the arctangents of one fifth and one over 239.
  function automatic longint pi4_q60();
    longint n;
    longint p;
    longint t;
    longint part;
    longint total;
    total = 0;
    for (int idx = 0; idx < 2; idx++) begin
      n    = (idx == 0) ? 64'sd5 : 64'sd239;
      p    = longint'(udiv64(64'd1 << 60, 64'(n)));
      part = 0;
      for (int k = 0; k < 40; k++) begin
        if (p != 0) begin
          t    = longint'(udiv64(64'(p), 64'(2 * k + 1)));
          part = (k % 2 == 1) ? part - t : part + t;
          p    = longint'(udiv64(64'(p), 64'(n * n)));
        end
      end
      total = (idx == 0) ? 4 * part : total - part;
    end
    return total;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  function automatic arc_tab_t arc_table();
    arc_tab_t tab;
    tab[0] = zval_t'((pi4_q60() + (longint'(1) << 19)) >>> 20);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      tab[i] = zval_t'((arc_pow2_q60(i) + (longint'(1) << 19)) >>> 20);
    end
    return tab;
  endfunction

  function automatic longint quarter_q40();
    return (2 * pi4_q60() + (longint'(1) << 19)) >>> 20;
  endfunction

  // Inverse CORDIC gain in the working format.
  function automatic longint gain_q();
    logic [63:0] g2;
    g2 = 64'd1 << 58;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
    end
    return longint'(udiv64(64'd1 << (WORK_FRAC + 29), isqrt64(g2)));
  endfunction

  function automatic longint root_half_q();
    return longint'((isqrt64(64'd1 << (2 * VAL_FRAC + 1)) + 64'd1) >> 1);
  endfunction

  localparam arc_tab_t         ARC_TAB    = arc_table();
  localparam logic [QT_W-1:0]  QUARTER_Q  = QT_W'(quarter_q40());
  localparam xy_t              GAIN_INIT  = XY_W'(gain_q());
  localparam val_t             VAL_UNIT   = VAL_W'(longint'(1) << VAL_FRAC);
  localparam val_t             ROOT_HALF  = VAL_W'(root_half_q());

endpackage

### hdl/qubit_gate_matrix_generator_core.sv
// Top level of the single-qubit gate matrix generator.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low. busy is always low: the datapath is fully pipelined and takes a new
// gate code with its three angles in every cycle, one transaction per cycle.
// Each transaction yields one 2x2 complex matrix in Q1.16 on the out_ ports,
// marked by out_valid for exactly one cycle. The result passes through the
// input register, angle scaling, the starting vector, one stage per rotation
// step (20), rounding and two output stages, 26 register stages in all.
// Five lanes run side by side so that U, with five sines and cosines, keeps
// the full rate. The receiver cannot stall the block; results are simply
// presented in order. A synchronous reset clears the valid bits, so no
// result appears after reset until a new transaction is accepted; data
// registers are not reset.
module qubit_gate_matrix_generator_core import qgm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_theta,
  input  logic signed [31:0] in_phi,
  input  logic signed [31:0] in_lambda_angle,
  output logic               out_valid,
  output logic signed [17:0] out_m00_re,
  output logic signed [17:0] out_m00_im,
  output logic signed [17:0] out_m01_re,
  output logic signed [17:0] out_m01_im,
  output logic signed [17:0] out_m10_re,
  output logic signed [17:0] out_m10_im,
  output logic signed [17:0] out_m11_re,
  output logic signed [17:0] out_m11_im
);

  logic       front_valid;
  logic [3:0] front_cmd;
  phase_arr_t phases;
  cs_arr_t    lanes;
  mat_t       mat;

  logic       valid_d_r [LANE_LAT];
  logic [3:0] cmd_d_r   [LANE_LAT];

  assign busy = 1'b0;

  qgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (start & ~busy),
    .cmd          (in_cmd),
    .theta        (phase_t'(in_theta)),
    .phi          (phase_t'(in_phi)),
    .lambda_angle (phase_t'(in_lambda_angle)),
    .valid        (front_valid),
    .cmd_q        (front_cmd),
    .phases       (phases)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    qgm_lane u_lane (
      .clk   (clk),
      .phase (phases[l]),
      .cs    (lanes[l])
    );
  end

  // Valid bit and gate code travel alongside the CORDIC lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) valid_d_r[i] <= 1'b0;
    end else begin
      valid_d_r[0] <= front_valid;
      for (int i = 1; i < LANE_LAT; i++) valid_d_r[i] <= valid_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    cmd_d_r[0] <= front_cmd;
    for (int i = 1; i < LANE_LAT; i++) cmd_d_r[i] <= cmd_d_r[i-1];
  end

  qgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (valid_d_r[LANE_LAT-1]),
    .cmd       (cmd_d_r[LANE_LAT-1]),
    .lanes     (lanes),
    .out_valid (out_valid),
    .mat       (mat)
  );

  assign out_m00_re = mat[0];
  assign out_m00_im = mat[1];
  assign out_m01_re = mat[2];
  assign out_m01_im = mat[3];
  assign out_m10_re = mat[4];
  assign out_m10_im = mat[5];
  assign out_m11_re = mat[6];
  assign out_m11_im = mat[7];

endmodule

### hdl/qgm_front.sv
// Input register stage: picks the phase that each CORDIC lane evaluates.
module qgm_front import qgm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [3:0]  cmd,
  input  phase_t      theta,
  input  phase_t      phi,
  input  phase_t      lambda_angle,
  output logic        valid,
  output logic [3:0]  cmd_q,
  output phase_arr_t  phases
);

  logic       valid_r;
  logic [3:0] cmd_r;
  phase_arr_t phase_r;
  phase_arr_t phase_nxt;

  // Lane 0 always takes theta; lanes 1 to 4 take the sums the gate needs.
  always_comb begin
    phase_nxt[0] = theta;
    for (int l = 1; l < NUM_LANES; l++) phase_nxt[l] = '0;
    case (cmd_t'(cmd))
      CMD_U, CMD_U2: begin
        phase_nxt[1] = phase_t'(0) - lambda_angle - phi;
        phase_nxt[2] = lambda_angle - phi;
        phase_nxt[3] = phi - lambda_angle;
        phase_nxt[4] = lambda_angle + phi;
      end
      CMD_U1: begin
        phase_nxt[1] = lambda_angle + lambda_angle;
      end
      CMD_RZ: begin
        phase_nxt[1] = phase_t'(0) - theta;
        phase_nxt[2] = theta;
      end
      CMD_EXPI_I: begin
        phase_nxt[1] = theta + theta;
      end
      CMD_EXPI_Z: begin
        phase_nxt[1] = theta + theta;
        phase_nxt[2] = phase_t'(0) - theta - theta;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd;
    phase_r <= phase_nxt;
  end

  assign valid  = valid_r;
  assign cmd_q  = cmd_r;
  assign phases = phase_r;

endmodule

### hdl/qgm_lane.sv
// One pipelined CORDIC lane: cosine and sine of a phase given in turns.
module qgm_lane import qgm_pkg::*; (
  input  logic   clk,
  input  phase_t phase,
  output cs_t    cs
);

  localparam int RB = ANGLE_BITS - 2;

  // Angle scaling stage.
  logic [1:0]  quad_p_r;
  logic        zero_p_r;
  logic [56:0] hi_prod_r;
  logic [56:0] lo_prod_r;

  // Rotation stages: index 0 holds the starting vector.
  xy_t        x_r    [CORDIC_STEPS+1];
  xy_t        y_r    [CORDIC_STEPS+1];
  zval_t      z_r    [CORDIC_STEPS+1];
  logic [1:0] quad_r [CORDIC_STEPS+1];
  logic       zero_r [CORDIC_STEPS+1];

  cs_t   cs_r;
  cs_t   cs_nxt;
  logic [57:0] z_sum;
  val_t  c_v;
  val_t  s_v;

  function automatic val_t round_clamp(xy_t v);
    logic signed [XY_W:0]   vs;
    logic signed [XY_W-4:0] vq;
    vs = {v[XY_W-1], v} + (XY_W+1)'(8);
    vq = vs[XY_W:4];
    if (vq > (XY_W-3)'(VAL_UNIT)) return VAL_UNIT;
    if (vq < -(XY_W-3)'(VAL_UNIT)) return -VAL_UNIT;
    return vq[VAL_W-1:0];
  endfunction

  // Quadrant split and the two partial products of the angle in radians.
  always_ff @(posedge clk) begin
    quad_p_r  <= phase[ANGLE_BITS-1 -: 2];
    zero_p_r  <= (phase[RB-1:0] == '0);
    hi_prod_r <= 57'(phase[RB-1 -: 16]) * 57'(QUARTER_Q);
    lo_prod_r <= 57'({phase[RB-17:0], 2'b00}) * 57'(QUARTER_Q);
  end

  assign z_sum = 58'(hi_prod_r) + 58'(lo_prod_r >> 16);

  // Starting vector, then one rotation per stage.
  always_ff @(posedge clk) begin
    x_r[0]    <= GAIN_INIT;
    y_r[0]    <= '0;
    z_r[0]    <= Z_W'(z_sum >> 16);
    quad_r[0] <= quad_p_r;
    zero_r[0] <= zero_p_r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z_r[i][Z_W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ARC_TAB[i];
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ARC_TAB[i];
      end
      quad_r[i+1] <= quad_r[i];
      zero_r[i+1] <= zero_r[i];
    end
  end

  // Round, saturate and fold the quadrant back in.
  always_comb begin
    if (zero_r[CORDIC_STEPS]) begin
      c_v = VAL_UNIT;
      s_v = '0;
    end else begin
      c_v = round_clamp(x_r[CORDIC_STEPS]);
      s_v = round_clamp(y_r[CORDIC_STEPS]);
    end
    case (quad_r[CORDIC_STEPS])
      2'd0:    begin cs_nxt.co = c_v;  cs_nxt.si = s_v;  end
      2'd1:    begin cs_nxt.co = -s_v; cs_nxt.si = c_v;  end
      2'd2:    begin cs_nxt.co = -c_v; cs_nxt.si = -s_v; end
      default: begin cs_nxt.co = s_v;  cs_nxt.si = -c_v; end
    endcase
  end

  always_ff @(posedge clk) begin
    cs_r <= cs_nxt;
  end

  assign cs = cs_r;

endmodule

### hdl/qgm_back.sv
// Output stages: scales the phase factors for U and U2 and assembles the matrix.
module qgm_back import qgm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid,
  input  logic [3:0] cmd,
  input  cs_arr_t    lanes,
  output logic       out_valid,
  output mat_t       mat
);

  typedef logic signed [2*VAL_W-1:0] prod_t;

  logic       valid_m_r;
  logic [3:0] cmd_m_r;
  cs_arr_t    lanes_m_r;
  prod_t      prod_r [NUM_OUT];
  val_t       kc;
  val_t       ks;

  logic       valid_o_r;
  mat_t       mat_r;
  mat_t       mat_nxt;

  function automatic val_t mulq(prod_t p);
    logic signed [2*VAL_W:0] ps;
    ps = {p[2*VAL_W-1], p} + (2*VAL_W+1)'(longint'(1) << (VAL_FRAC - 1));
    return ps[VAL_FRAC +: VAL_W];
  endfunction

  // Multiply stage: U scales by cos and sin of theta, U2 by root one half.
  always_comb begin
    if (cmd_t'(cmd) == CMD_U2) begin
      kc = ROOT_HALF;
      ks = ROOT_HALF;
    end else begin
      kc = lanes[0].co;
      ks = lanes[0].si;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_m_r <= 1'b0;
      valid_o_r <= 1'b0;
    end else begin
      valid_m_r <= valid;
      valid_o_r <= valid_m_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_m_r   <= cmd;
    lanes_m_r <= lanes;
    prod_r[0] <= lanes[1].co * kc;
    prod_r[1] <= lanes[1].si * kc;
    prod_r[2] <= lanes[2].co * ks;
    prod_r[3] <= lanes[2].si * ks;
    prod_r[4] <= lanes[3].co * ks;
    prod_r[5] <= lanes[3].si * ks;
    prod_r[6] <= lanes[4].co * kc;
    prod_r[7] <= lanes[4].si * kc;
  end

  // Assembly stage: one entry set per gate code.
  always_comb begin
    for (int j = 0; j < NUM_OUT; j++) mat_nxt[j] = '0;
    case (cmd_t'(cmd_m_r))
      CMD_U, CMD_U2: begin
        mat_nxt[0] = mulq(prod_r[0]);
        mat_nxt[1] = mulq(prod_r[1]);
        mat_nxt[2] = -mulq(prod_r[2]);
        mat_nxt[3] = -mulq(prod_r[3]);
        mat_nxt[4] = mulq(prod_r[4]);
        mat_nxt[5] = mulq(prod_r[5]);
        mat_nxt[6] = mulq(prod_r[6]);
        mat_nxt[7] = mulq(prod_r[7]);
      end
      CMD_U1: begin
        mat_nxt[0] = VAL_UNIT;
        mat_nxt[6] = lanes_m_r[1].co;
        mat_nxt[7] = lanes_m_r[1].si;
      end
      CMD_ID: begin
        mat_nxt[0] = VAL_UNIT;
        mat_nxt[6] = VAL_UNIT;
      end
      CMD_X: begin
        mat_nxt[2] = VAL_UNIT;
        mat_nxt[4] = VAL_UNIT;
      end
      CMD_Y: begin
        mat_nxt[3] = -VAL_UNIT;
        mat_nxt[5] = VAL_UNIT;
      end
      CMD_Z: begin
        mat_nxt[0] = VAL_UNIT;
        mat_nxt[6] = -VAL_UNIT;
      end
      CMD_H: begin
        mat_nxt[0] = ROOT_HALF;
        mat_nxt[2] = ROOT_HALF;
        mat_nxt[4] = ROOT_HALF;
        mat_nxt[6] = -ROOT_HALF;
      end
      CMD_S: begin
        mat_nxt[0] = VAL_UNIT;
        mat_nxt[7] = VAL_UNIT;
      end
      CMD_T: begin
        mat_nxt[0] = VAL_UNIT;
        mat_nxt[6] = ROOT_HALF;
        mat_nxt[7] = ROOT_HALF;
      end
      CMD_RX: begin
        mat_nxt[0] = lanes_m_r[0].co;
        mat_nxt[3] = -lanes_m_r[0].si;
        mat_nxt[5] = -lanes_m_r[0].si;
        mat_nxt[6] = lanes_m_r[0].co;
      end
      CMD_RY: begin
        mat_nxt[0] = lanes_m_r[0].co;
        mat_nxt[2] = -lanes_m_r[0].si;
        mat_nxt[4] = lanes_m_r[0].si;
        mat_nxt[6] = lanes_m_r[0].co;
      end
      CMD_RZ, CMD_EXPI_Z: begin
        mat_nxt[0] = lanes_m_r[1].co;
        mat_nxt[1] = lanes_m_r[1].si;
        mat_nxt[6] = lanes_m_r[2].co;
        mat_nxt[7] = lanes_m_r[2].si;
      end
      CMD_EXPI_I: begin
        mat_nxt[0] = lanes_m_r[1].co;
        mat_nxt[1] = lanes_m_r[1].si;
        mat_nxt[6] = lanes_m_r[1].co;
        mat_nxt[7] = lanes_m_r[1].si;
      end
      default: begin
        mat_nxt[0] = ROOT_HALF;
        mat_nxt[2] = ROOT_HALF;
        mat_nxt[5] = ROOT_HALF;
        mat_nxt[7] = -ROOT_HALF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign out_valid = valid_o_r;
  assign mat       = mat_r;

endmodule

### sim/tb_qubit_gate_matrix_generator_core.sv
// Self-checking testbench for the single-qubit gate matrix generator core.
`timescale 1ns / 1ps

module tb_qubit_gate_matrix_generator_core import qgm_pkg::*; ();

  typedef logic [7:0][17:0] gate_mat_t;

  typedef struct {
    cmd_t      cmd;
    logic [31:0] th;
    logic [31:0] ph;
    logic [31:0] la;
    bit        typed;
    gate_mat_t mat;
  } gate_req_t;

  localparam longint ONE_Q16 = 64'sd65536;
  localparam longint RH_Q16  = 64'sd46341;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [3:0] in_cmd;
  logic signed [31:0] in_theta;
  logic signed [31:0] in_phi;
  logic signed [31:0] in_lambda_angle;
  logic out_valid;
  logic signed [17:0] out_m00_re, out_m00_im, out_m01_re, out_m01_im;
  logic signed [17:0] out_m10_re, out_m10_im, out_m11_re, out_m11_im;

  longint    atan_q40 [20];
  longint    quarter_pi_q40;
  longint    cordic_gain;
  gate_mat_t pending_mats [$];
  gate_req_t directed_reqs [$];
  int        errors;
  bit        stim_done;

  string field_names [8] = '{"m00_re", "m00_im", "m01_re", "m01_im",
                             "m10_re", "m10_im", "m11_re", "m11_im"};

  qubit_gate_matrix_generator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_theta(in_theta), .in_phi(in_phi),
    .in_lambda_angle(in_lambda_angle), .out_valid(out_valid),
    .out_m00_re(out_m00_re), .out_m00_im(out_m00_im),
    .out_m01_re(out_m01_re), .out_m01_im(out_m01_im),
    .out_m10_re(out_m10_re), .out_m10_im(out_m10_im),
    .out_m11_re(out_m11_re), .out_m11_im(out_m11_im)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Arctangent of 1/n in Q60 by its power series.
  function automatic longint atan_recip_q60(longint n);
    logic [63:0] p;
    longint sum;
    sum = 0;
    p = (64'd1 << 60) / n;
    for (int k = 0; p != 0; k++) begin
      sum = (k % 2 == 1) ? sum - longint'(p / (2 * k + 1)) : sum + longint'(p / (2 * k + 1));
      p = p / (n * n);
    end
    return sum;
  endfunction

  // Arctangent of two to the minus i in Q60.
  function automatic longint atan_pow2_q60(int i);
    longint sum;
    int e;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e >= 60) break;
      sum = (k % 2 == 1) ? sum - longint'((64'd1 << (60 - e)) / (2 * k + 1))
                         : sum + longint'((64'd1 << (60 - e)) / (2 * k + 1));
    end
    return sum;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Rotation angles, quarter turn and gain correction of the CORDIC.
  function automatic void build_cordic_consts();
    longint quarter_pi;
    logic [63:0] g2;
    quarter_pi = 4 * atan_recip_q60(5) - atan_recip_q60(239);
    atan_q40[0] = (quarter_pi + (64'sd1 <<< 19)) >>> 20;
    for (int i = 1; i < 20; i++) atan_q40[i] = (atan_pow2_q60(i) + (64'sd1 <<< 19)) >>> 20;
    quarter_pi_q40 = (2 * quarter_pi + (64'sd1 <<< 19)) >>> 20;
    g2 = 64'd1 << 58;
    for (int i = 0; i < 20; i++) g2 = g2 + (g2 >> (2 * i));
    cordic_gain = longint'((64'd1 << 49) / int_sqrt(g2));
  endfunction

  function automatic longint sat_unit(longint v);
    if (v > ONE_Q16) return ONE_Q16;
    if (v < -ONE_Q16) return -ONE_Q16;
    return v;
  endfunction

  // Cosine and sine of a phase counted in 2^-32 turns.
  function automatic void phase_cos_sin(input logic [31:0] p, output longint co,
                                        output longint si);
    logic [63:0] r32;
    longint c, s, x, y, z, dx, dy;
    r32 = {32'd0, p[29:0], 2'b00};
    if (p[29:0] == 0) begin
      c = ONE_Q16;
      s = 0;
    end else begin
      z = longint'(((r32 >> 16) * quarter_pi_q40
                    + (((r32 & 64'hFFFF) * quarter_pi_q40) >> 16)) >> 16);
      x = cordic_gain;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q40[i];
        end else begin
          x += dx; y -= dy; z += atan_q40[i];
        end
      end
      c = sat_unit((x + 8) >>> 4);
      s = sat_unit((y + 8) >>> 4);
    end
    case (p[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  // Full matrix for one gate request.
  function automatic gate_mat_t gate_matrix(cmd_t cmd, logic [31:0] th, logic [31:0] ph,
                                            logic [31:0] la);
    longint m [8];
    longint c, s, ec, es, k;
    logic [31:0] eph [4];
    gate_mat_t r;
    for (int j = 0; j < 8; j++) m[j] = 0;
    case (cmd)
      CMD_U, CMD_U2: begin
        if (cmd == CMD_U) phase_cos_sin(th, c, s);
        else begin
          c = RH_Q16; s = RH_Q16;
        end
        eph[0] = 32'd0 - la - ph;
        eph[1] = la - ph;
        eph[2] = ph - la;
        eph[3] = la + ph;
        for (int e = 0; e < 4; e++) begin
          phase_cos_sin(eph[e], ec, es);
          k = (e == 0 || e == 3) ? c : s;
          m[2*e]   = (e == 1) ? -mul_q16(ec, k) : mul_q16(ec, k);
          m[2*e+1] = (e == 1) ? -mul_q16(es, k) : mul_q16(es, k);
        end
      end
      CMD_U1: begin
        m[0] = ONE_Q16;
        phase_cos_sin(la + la, m[6], m[7]);
      end
      CMD_ID: begin m[0] = ONE_Q16; m[6] = ONE_Q16; end
      CMD_X:  begin m[2] = ONE_Q16; m[4] = ONE_Q16; end
      CMD_Y:  begin m[3] = -ONE_Q16; m[5] = ONE_Q16; end
      CMD_Z:  begin m[0] = ONE_Q16; m[6] = -ONE_Q16; end
      CMD_H:  begin m[0] = RH_Q16; m[2] = RH_Q16; m[4] = RH_Q16; m[6] = -RH_Q16; end
      CMD_S:  begin m[0] = ONE_Q16; m[7] = ONE_Q16; end
      CMD_T:  begin m[0] = ONE_Q16; m[6] = RH_Q16; m[7] = RH_Q16; end
      CMD_RX: begin
        phase_cos_sin(th, c, s);
        m[0] = c; m[3] = -s; m[5] = -s; m[6] = c;
      end
      CMD_RY: begin
        phase_cos_sin(th, c, s);
        m[0] = c; m[2] = -s; m[4] = s; m[6] = c;
      end
      CMD_RZ: begin
        phase_cos_sin(32'd0 - th, m[0], m[1]);
        phase_cos_sin(th, m[6], m[7]);
      end
      CMD_EXPI_I: begin
        phase_cos_sin(th + th, m[0], m[1]);
        m[6] = m[0]; m[7] = m[1];
      end
      CMD_EXPI_Z: begin
        phase_cos_sin(th + th, m[0], m[1]);
        phase_cos_sin(32'd0 - th - th, m[6], m[7]);
      end
      default: begin m[0] = RH_Q16; m[2] = RH_Q16; m[5] = RH_Q16; m[7] = -RH_Q16; end
    endcase
    for (int j = 0; j < 8; j++) r[j] = m[j][17:0];
    return r;
  endfunction

  function automatic gate_mat_t mat_of(int a0, int a1, int a2, int a3, int a4, int a5,
                                       int a6, int a7);
    gate_mat_t r;
    r = {18'(a7), 18'(a6), 18'(a5), 18'(a4), 18'(a3), 18'(a2), 18'(a1), 18'(a0)};
    return r;
  endfunction

  function automatic void add_req(cmd_t cmd, logic [31:0] th, logic [31:0] ph,
                                  logic [31:0] la, bit typed, gate_mat_t mat);
    gate_req_t q;
    q.cmd = cmd; q.th = th; q.ph = ph; q.la = la; q.typed = typed; q.mat = mat;
    directed_reqs.push_back(q);
  endfunction

  // Directed rows: fixed gates, zero angles and a quarter-turn RY are typed in, the rest predicted.
  function automatic void build_directed();
    gate_mat_t z;
    z = '0;
    add_req(CMD_ID, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
            mat_of(65536, 0, 0, 0, 0, 0, 65536, 0));
    add_req(CMD_X, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1,
            mat_of(0, 0, 65536, 0, 65536, 0, 0, 0));
    add_req(CMD_Y, 0, 0, 0, 1, mat_of(0, 0, 0, -65536, 0, 65536, 0, 0));
    add_req(CMD_Z, 32'h1234_5678, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, -65536, 0));
    add_req(CMD_H, 0, 0, 0, 1, mat_of(46341, 0, 46341, 0, 46341, 0, -46341, 0));
    add_req(CMD_S, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 0, 65536));
    add_req(CMD_T, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 46341, 46341));
    add_req(CMD_SH, 0, 0, 0, 1, mat_of(46341, 0, 46341, 0, 0, 46341, 0, -46341));
    add_req(CMD_RX, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 65536, 0));
    add_req(CMD_RY, 32'h4000_0000, 0, 0, 1, mat_of(0, 0, -65536, 0, 65536, 0, 0, 0));
    add_req(CMD_RZ, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 65536, 0));
    add_req(CMD_U1, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 65536, 0));
    add_req(CMD_U, 0, 0, 0, 1, mat_of(65536, 0, 0, 0, 0, 0, 65536, 0));
    // Quadrant boundaries, extremes of the angle range and the angled gates.
    add_req(CMD_RX, 32'h8000_0000, 0, 0, 0, z);
    add_req(CMD_RY, 32'hC000_0000, 0, 0, 0, z);
    add_req(CMD_RZ, 32'h7FFF_FFFF, 0, 0, 0, z);
    add_req(CMD_RX, 32'h0000_0001, 0, 0, 0, z);
    add_req(CMD_EXPI_I, 32'hFFFF_FFFF, 0, 0, 0, z);
    add_req(CMD_EXPI_Z, 32'h2000_0000, 0, 0, 0, z);
    add_req(CMD_U1, 0, 0, 32'h8000_0000, 0, z);
    add_req(CMD_U2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, z);
    add_req(CMD_U, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 0, z);
    add_req(CMD_U, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, z);
    add_req(CMD_U, 32'h1555_5555, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0, z);
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 3) == 0 ? 2'b00 : 2'($urandom), 30'd0};
      1: return 32'($urandom_range(0, 7)) - 32'd4;
      2: return {$urandom_range(0, 1) == 0 ? 2'b01 : 2'b11, 30'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed rows, then random requests with random idle cycles.
  initial begin
    gate_req_t q;
    int n_sent;
    int n_total;
    bit idle;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_theta = '0;
    in_phi = '0;
    in_lambda_angle = '0;
    errors = 0;
    stim_done = 1'b0;
    build_cordic_consts();
    build_directed();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    n_total = directed_reqs.size() + 1300;
    n_sent = 0;
    q = directed_reqs[0];
    while (n_sent < n_total) begin
      @(posedge clk);
      if (start && !busy) begin
        pending_mats.push_back(q.typed ? q.mat : gate_matrix(q.cmd, q.th, q.ph, q.la));
        n_sent++;
        if (n_sent < directed_reqs.size()) begin
          q = directed_reqs[n_sent];
        end else begin
          q.cmd = cmd_t'($urandom_range(0, 15));
          q.th = rand_angle();
          q.ph = rand_angle();
          q.la = rand_angle();
          q.typed = 1'b0;
        end
      end
      // A stretch of random requests runs with no idle cycles at all.
      idle = (n_sent > 300 && n_sent < 700) ? 1'b0 : ($urandom_range(0, 99) < 20);
      if (n_sent < n_total && !idle) begin
        start <= 1'b1;
        in_cmd <= q.cmd;
        in_theta <= q.th;
        in_phi <= q.ph;
        in_lambda_angle <= q.la;
      end else begin
        start <= 1'b0;
        in_cmd <= 4'($urandom);
        in_theta <= $urandom;
      end
    end
    stim_done = 1'b1;
  end

  // Result checking against the oldest expected matrix.
  always @(posedge clk) begin
    gate_mat_t got, want;
    if (rst_n && out_valid) begin
      got = {out_m11_im, out_m11_re, out_m10_im, out_m10_re,
             out_m01_im, out_m01_re, out_m00_im, out_m00_re};
      if (pending_mats.size() == 0) begin
        $display("%0t: unexpected result transaction, got %h", $time, got);
        errors++;
      end else begin
        want = pending_mats.pop_front();
        for (int j = 0; j < 8; j++) begin
          if (got[j] !== want[j]) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field_names[j],
                     $signed(want[j]), $signed(got[j]));
            errors++;
          end
        end
      end
    end
  end

  // Drain the pipeline and report.
  initial begin
    wait (stim_done);
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
